// File: rtl/rotation_matrix_to_quaternion_unit_defines.svh
// Assertion macros for the rotation matrix to quaternion unit.
// Included by the top level; expects clk and rst_n in scope.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define RMQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rmq_pkg.sv
// Types and constants for the rotation matrix to quaternion unit.
// Self-contained; used by every module of the block.
package rmq_pkg;

  localparam int NSQ    = 5;
  localparam int RAD_W  = 32;
  localparam int ROOT_W = 16;
  localparam int SREM_W = 20;
  localparam int NDV    = 3;
  localparam int Q_W    = 16;

  localparam logic signed [17:0] ONE_Q14 = 18'sd16384;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } rmq_in_t;

  typedef struct packed {
    logic signed [15:0] q_w;
    logic signed [15:0] q_x;
    logic signed [15:0] q_y;
    logic signed [15:0] q_z;
  } rmq_out_t;

  typedef struct packed {
    logic                        tpos;
    logic [NDV-1:0]              dneg;
    logic [NDV-1:0][15:0]        dmag;
    logic [NSQ-1:0][RAD_W-1:0]   rad;
    logic [NSQ-1:0][SREM_W-1:0]  rem;
    logic [NSQ-1:0][ROOT_W-1:0]  root;
  } rmq_sq_t;

  typedef struct packed {
    logic                        tpos;
    logic [NDV-1:0]              dneg;
    logic [3:0][ROOT_W-1:0]      hr;
    logic [ROOT_W-1:0]           r14;
    logic [NDV-1:0][ROOT_W-1:0]  rem;
    logic [NDV-1:0][15:0]        lo;
    logic [NDV-1:0][Q_W-1:0]     q;
  } rmq_dv_t;

endpackage

// File: rtl/rmq_sqrt_cell.sv
// One digit cell of the square root chain: one root bit for every radicand.
// Depends on rmq_pkg.
module rmq_sqrt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  rmq_pkg::rmq_sq_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output rmq_pkg::rmq_sq_t dn_data
);
  import rmq_pkg::*;

  rmq_sq_t step;
  logic    valid_r;
  rmq_sq_t data_r;

  always_comb begin
    logic [SREM_W-1:0] cur;
    logic [SREM_W-1:0] trial;
    step = up_data;
    for (int c = 0; c < NSQ; c++) begin
      cur   = {up_data.rem[c][SREM_W-3:0], up_data.rad[c][RAD_W-1 -: 2]};
      trial = {{(SREM_W-ROOT_W-2){1'b0}}, up_data.root[c], 2'b01};
      step.rad[c] = {up_data.rad[c][RAD_W-3:0], 2'b00};
      if (cur >= trial) begin
        step.rem[c]  = cur - trial;
        step.root[c] = {up_data.root[c][ROOT_W-2:0], 1'b1};
      end else begin
        step.rem[c]  = cur;
        step.root[c] = {up_data.root[c][ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= step;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: rtl/rmq_div_cell.sv
// One digit cell of the division chain: one quotient bit for each component.
// Depends on rmq_pkg.
module rmq_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  rmq_pkg::rmq_dv_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output rmq_pkg::rmq_dv_t dn_data
);
  import rmq_pkg::*;

  rmq_dv_t step;
  logic    valid_r;
  rmq_dv_t data_r;

  always_comb begin
    logic [ROOT_W:0] cur;
    step = up_data;
    for (int c = 0; c < NDV; c++) begin
      cur = {up_data.rem[c], up_data.lo[c][15]};
      step.lo[c] = {up_data.lo[c][14:0], 1'b0};
      if (cur >= {1'b0, up_data.r14}) begin
        step.rem[c] = ROOT_W'(cur - {1'b0, up_data.r14});
        step.q[c]   = {up_data.q[c][Q_W-2:0], 1'b1};
      end else begin
        step.rem[c] = cur[ROOT_W-1:0];
        step.q[c]   = {up_data.q[c][Q_W-2:0], 1'b0};
      end
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= step;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

// File: rtl/rotation_matrix_to_quaternion_unit.sv
// Channel   Signals                        Payload
// input     in_valid, in_stall, in_data    rmq_in_t, nine Q2.14 entries
// result    out_valid, out_stall, out_data rmq_out_t, quaternion in Q2.14
//
// One matrix is accepted per cycle while in_stall is low.
// The pipeline is 16 square root cells, 16 division cells and the output register.
// Every cell holds its own valid bit, so bubbles close up under a stall.
// Reset clears only the valid bits. Depends on rmq_pkg, both cell modules and the defines header.
module rotation_matrix_to_quaternion_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rmq_pkg::rmq_in_t  in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rmq_pkg::rmq_out_t out_data
);
  import rmq_pkg::*;
  `include "rotation_matrix_to_quaternion_unit_defines.svh"

  localparam int SQ_CELLS = ROOT_W;
  localparam int DV_CELLS = Q_W;

  logic    sq_valid [SQ_CELLS+1];
  logic    sq_ready [SQ_CELLS+1];
  rmq_sq_t sq_data  [SQ_CELLS+1];
  logic    dv_valid [DV_CELLS+1];
  logic    dv_ready [DV_CELLS+1];
  rmq_dv_t dv_data  [DV_CELLS+1];

  logic     out_valid_r;
  rmq_out_t out_data_r;
  rmq_out_t fin;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      return 16'sh7fff;
    end else if (v < -17'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  always_comb begin
    logic signed [17:0] m00e, m11e, m22e, t, a_s, bx, by, bz;
    logic signed [16:0] dx, dy, dz;
    logic [16:0] a_u, bxu, byu, bzu;
    m00e = 18'(in_data.m00);
    m11e = 18'(in_data.m11);
    m22e = 18'(in_data.m22);
    t    = m00e + m11e + m22e;
    a_s  = ONE_Q14 + t;
    bx   = ONE_Q14 + m00e - m11e - m22e;
    by   = ONE_Q14 - m00e + m11e - m22e;
    bz   = ONE_Q14 - m00e - m11e + m22e;
    a_u  = a_s[17] ? '0 : a_s[16:0];
    bxu  = bx[17] ? '0 : bx[16:0];
    byu  = by[17] ? '0 : by[16:0];
    bzu  = bz[17] ? '0 : bz[16:0];
    dx   = 17'(in_data.m21) - 17'(in_data.m12);
    dy   = 17'(in_data.m02) - 17'(in_data.m20);
    dz   = 17'(in_data.m10) - 17'(in_data.m01);
    sq_data[0].tpos    = !t[17] && (t != '0);
    sq_data[0].dneg    = {dz[16], dy[16], dx[16]};
    sq_data[0].dmag[0] = dx[16] ? 16'(-dx) : dx[15:0];
    sq_data[0].dmag[1] = dy[16] ? 16'(-dy) : dy[15:0];
    sq_data[0].dmag[2] = dz[16] ? 16'(-dz) : dz[15:0];
    sq_data[0].rad[0]  = {3'b000, a_u, 12'h000};
    sq_data[0].rad[1]  = {1'b0, a_u, 14'h0000};
    sq_data[0].rad[2]  = {3'b000, bxu, 12'h000};
    sq_data[0].rad[3]  = {3'b000, byu, 12'h000};
    sq_data[0].rad[4]  = {3'b000, bzu, 12'h000};
    sq_data[0].rem     = '0;
    sq_data[0].root    = '0;
  end

  assign sq_valid[0] = in_valid;
  assign in_stall    = !sq_ready[0];

  for (genvar i = 0; i < SQ_CELLS; i++) begin : g_sq
    rmq_sqrt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (sq_valid[i]),
      .up_ready (sq_ready[i]),
      .up_data  (sq_data[i]),
      .dn_valid (sq_valid[i+1]),
      .dn_ready (sq_ready[i+1]),
      .dn_data  (sq_data[i+1])
    );
  end

  always_comb begin
    logic [ROOT_W-1:0] r14;
    logic [29:0]       num;
    r14 = sq_data[SQ_CELLS].root[1];
    dv_data[0].tpos  = sq_data[SQ_CELLS].tpos;
    dv_data[0].dneg  = sq_data[SQ_CELLS].dneg;
    dv_data[0].hr[0] = sq_data[SQ_CELLS].root[0];
    dv_data[0].hr[1] = sq_data[SQ_CELLS].root[2];
    dv_data[0].hr[2] = sq_data[SQ_CELLS].root[3];
    dv_data[0].hr[3] = sq_data[SQ_CELLS].root[4];
    dv_data[0].r14   = r14;
    dv_data[0].q     = '0;
    for (int c = 0; c < NDV; c++) begin
      num = {1'b0, sq_data[SQ_CELLS].dmag[c], 13'h0000} + 30'(r14[ROOT_W-1:1]);
      dv_data[0].rem[c] = {2'b00, num[29:16]};
      dv_data[0].lo[c]  = num[15:0];
    end
  end

  assign dv_valid[0]        = sq_valid[SQ_CELLS];
  assign sq_ready[SQ_CELLS] = dv_ready[0];

  for (genvar i = 0; i < DV_CELLS; i++) begin : g_dv
    rmq_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (dv_valid[i]),
      .up_ready (dv_ready[i]),
      .up_data  (dv_data[i]),
      .dn_valid (dv_valid[i+1]),
      .dn_ready (dv_ready[i+1]),
      .dn_data  (dv_data[i+1])
    );
  end

  always_comb begin
    logic signed [16:0] mag;
    logic signed [16:0] val [NDV];
    for (int c = 0; c < NDV; c++) begin
      if (dv_data[DV_CELLS].tpos) begin
        mag = {1'b0, dv_data[DV_CELLS].q[c]};
      end else begin
        mag = {1'b0, dv_data[DV_CELLS].hr[c+1]};
      end
      val[c] = dv_data[DV_CELLS].dneg[c] ? -mag : mag;
    end
    fin.q_w = sat16({1'b0, dv_data[DV_CELLS].hr[0]});
    fin.q_x = sat16(val[0]);
    fin.q_y = sat16(val[1]);
    fin.q_z = sat16(val[2]);
  end

  assign dv_ready[DV_CELLS] = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dv_ready[DV_CELLS]) begin
      out_valid_r <= dv_valid[DV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready[DV_CELLS] && dv_valid[DV_CELLS]) begin
      out_data_r <= fin;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RMQ_ASSERT_NOW(a_w_nonneg, out_valid, !out_data.q_w[15], "scalar part is negative")
  `RMQ_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without cause")
  `RMQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result lost")

endmodule

// File: tb/rotation_matrix_to_quaternion_unit_tb.sv
// Testbench for the rotation matrix to quaternion unit: directed and random matrices,
// checked field by field against a predictor of the fixed-point conversion.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion_unit top level.
module rotation_matrix_to_quaternion_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rmq_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  rmq_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rmq_out_t out_data;

  rmq_out_t quat_queue[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit no_idle = 1'b0;

  rotation_matrix_to_quaternion_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic longint half_sqrt(longint b);
    if (b < 0) b = 0;
    return longint'(int_sqrt(longint'(b) * 4096));
  endfunction

  function automatic logic signed [15:0] ratio_term(longint d, longint r14);
    longint mag;
    longint q;
    mag = (d < 0 ? -d : d) * 8192;
    q = (mag + r14 / 2) / r14;
    return clip16(d < 0 ? -q : q);
  endfunction

  function automatic rmq_out_t matrix_to_quat(rmq_in_t m);
    rmq_out_t q;
    longint t, a, dx, dy, dz, r14, e00, e11, e22;
    e00 = m.m00;
    e11 = m.m11;
    e22 = m.m22;
    t = e00 + e11 + e22;
    a = 16384 + t;
    dx = longint'(m.m21) - longint'(m.m12);
    dy = longint'(m.m02) - longint'(m.m20);
    dz = longint'(m.m10) - longint'(m.m01);
    if (a < 0) a = 0;
    q.q_w = clip16(half_sqrt(a));
    if (t > 0) begin
      r14 = longint'(int_sqrt(a * 16384));
      if (r14 == 0) r14 = 1;
      q.q_x = ratio_term(dx, r14);
      q.q_y = ratio_term(dy, r14);
      q.q_z = ratio_term(dz, r14);
    end else begin
      q.q_x = clip16(dx < 0 ? -half_sqrt(16384 + e00 - e11 - e22)
                            : half_sqrt(16384 + e00 - e11 - e22));
      q.q_y = clip16(dy < 0 ? -half_sqrt(16384 - e00 + e11 - e22)
                            : half_sqrt(16384 - e00 + e11 - e22));
      q.q_z = clip16(dz < 0 ? -half_sqrt(16384 - e00 - e11 + e22)
                            : half_sqrt(16384 - e00 - e11 + e22));
    end
    return q;
  endfunction

  task automatic send_matrix(rmq_in_t m);
    while (!no_idle && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= m;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    quat_queue.push_back(matrix_to_quat(m));
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= !no_idle && ($urandom_range(99) < 29);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (quat_queue.size() == 0) begin
        $error("result transfer with no expected result");
        error_count++;
      end else begin
        rmq_out_t e;
        e = quat_queue.pop_front();
        if (out_data.q_w !== e.q_w) begin
          $error("q_w expected %0d actual %0d", e.q_w, out_data.q_w);
          error_count++;
        end
        if (out_data.q_x !== e.q_x) begin
          $error("q_x expected %0d actual %0d", e.q_x, out_data.q_x);
          error_count++;
        end
        if (out_data.q_y !== e.q_y) begin
          $error("q_y expected %0d actual %0d", e.q_y, out_data.q_y);
          error_count++;
        end
        if (out_data.q_z !== e.q_z) begin
          $error("q_z expected %0d actual %0d", e.q_z, out_data.q_z);
          error_count++;
        end
      end
    end
    if (cycle_count > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic rmq_in_t make_matrix(int a0, int a1, int a2, int a3, int a4,
                                          int a5, int a6, int a7, int a8);
    rmq_in_t m;
    m = {a0[15:0], a1[15:0], a2[15:0], a3[15:0], a4[15:0],
         a5[15:0], a6[15:0], a7[15:0], a8[15:0]};
    return m;
  endfunction

  task automatic test_directed();
    send_matrix(make_matrix(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
    send_matrix(make_matrix(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
    send_matrix(make_matrix(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
    send_matrix(make_matrix(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
    send_matrix(make_matrix(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
    send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(0, 5, -7, 9, 0, -3, 4, 6, 0));
    send_matrix(make_matrix(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
    send_matrix(make_matrix(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
    send_matrix(make_matrix(32767, -32768, 32767, -32768, 32767, 32767,
                            -32768, -32768, 32767));
    send_matrix(make_matrix(1, 32767, -32768, -32768, 0, -32768, 32767, 32767, 0));
    send_matrix(make_matrix(-32768, 32767, 32767, 32767, -32768, 32767,
                            32767, 32767, -32768));
    send_matrix(make_matrix(-32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768));
    send_matrix(make_matrix(32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 32767, 32767));
    send_matrix(make_matrix(1, -1, 1, -1, 0, 1, -1, -1, 0));
    send_matrix(make_matrix(-16384, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random(int n);
    rmq_in_t m;
    int c, s;
    for (int i = 0; i < n; i++) begin
      m = rmq_in_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
      if ($urandom_range(99) < 70) begin
        c = $urandom_range(3);
        s = $urandom_range(16384);
        m.m00 = 16'($signed($urandom_range(32767)) - 16384);
        m.m11 = 16'($signed($urandom_range(32767)) - 16384);
        m.m22 = 16'($signed($urandom_range(32767)) - 16384);
        m.m01 = 16'($signed($urandom_range(2 * s)) - s);
        m.m10 = 16'($signed($urandom_range(2 * s)) - s);
        m.m02 = 16'($signed($urandom_range(2 * s)) - s);
        m.m20 = 16'($signed($urandom_range(2 * s)) - s);
        m.m12 = 16'($signed($urandom_range(2 * s)) - s);
        m.m21 = 16'($signed($urandom_range(2 * s)) - s);
        if (c == 0) m.m12 = m.m21;
      end
      send_matrix(m);
    end
  endtask

  task automatic test_drain_pause();
    in_valid <= 1'b0;
    while (quat_queue.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(600);
    test_drain_pause();
    no_idle = 1'b1;
    test_random(400);
    no_idle = 1'b0;
    test_random(934);
    test_drain_pause();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// File: sim.f
+incdir+rtl
rtl/rmq_pkg.sv
rtl/rmq_sqrt_cell.sv
rtl/rmq_div_cell.sv
rtl/rotation_matrix_to_quaternion_unit.sv
tb/rotation_matrix_to_quaternion_unit_tb.sv
